[rtl/oep_pkg.sv]
// ----------------------------------------------------------------------------
// oep_pkg: shared constants and types for the orbit eye position block
// Widths of the pipeline arithmetic, CORDIC arctangent table, register map.
// ----------------------------------------------------------------------------
package oep_pkg;

  localparam int EYE_DISTANCE = 512;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  // prep stage + one stage per rotation + rounding stage
  localparam int CORDIC_LAT   = CORDIC_N + 2;
  // input stage, angle/radius stage, CORDIC, two product stages, output stage
  localparam int LATENCY      = CORDIC_LAT + 5;

  localparam int XY_W   = 34;
  localparam int Z_W    = 33;
  localparam int TRIG_W = 17;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam int RSUM_W  = 33;
  localparam int EYE_W   = $clog2(EYE_DISTANCE + 1) + 1;
  localparam int RPROD_W = RSUM_W + EYE_W;
  localparam int RQ_W    = RPROD_W - 15;
  localparam int PROD_W  = TRIG_W + RQ_W;
  localparam int RND_W   = PROD_W - 27;
  localparam int SUM_W   = (RND_W + 1 > 25) ? RND_W + 1 : 25;
  localparam int OUT_W   = 24;

  localparam logic signed [EYE_W-1:0]     EYE_S       = EYE_W'(EYE_DISTANCE);
  localparam logic signed [RPROD_W-1:0]   HALF_RQ     = RPROD_W'(16384);
  localparam logic signed [XY_W:0]        HALF_CORDIC = (XY_W+1)'(16384);
  localparam logic signed [XY_W:0]        TRIG_MAX    = (XY_W+1)'(32768);
  localparam logic signed [XY_W:0]        TRIG_MIN    = -(XY_W+1)'(32768);
  localparam logic signed [2*TRIG_W-1:0]  HALF_TRIG   = (2*TRIG_W)'(16384);
  localparam logic signed [PROD_W-1:0]    HALF_PROD   = PROD_W'(1) <<< 26;
  localparam logic signed [SUM_W-1:0]     OUT_MAX     = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0]     OUT_MIN     = -SUM_W'(8388608);

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_RADIUS_START  = 3'd0,
    REG_RADIUS_DELTA  = 3'd1,
    REG_ZENITH_START  = 3'd2,
    REG_ZENITH_DELTA  = 3'd3,
    REG_AZIMUTH_START = 3'd4,
    REG_AZIMUTH_DELTA = 3'd5,
    REG_CENTER_POINT  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sine;
    logic signed [TRIG_W-1:0] cosine;
  } sincos_t;

endpackage

[rtl/orbit_eye_position.sv]
// ----------------------------------------------------------------------------
// orbit_eye_position: eye point on an orbit from a progress value
// From start to done an item passes stages A and B, the two parallel CORDIC
// pipelines of one stage per rotation, and stages C, D and E.
// Throughput: one transaction per cycle; busy is high only during reset.
// Reset clears all valid bits and loads register defaults; in-flight items drop.
// ----------------------------------------------------------------------------
module orbit_eye_position (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [15:0]                 progress,
  output logic                        done,
  output logic signed [23:0]          eye_x,
  output logic signed [23:0]          eye_y,
  output logic signed [23:0]          eye_z,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oep_pkg::ADDR_W-1:0]  paddr,
  input  logic [oep_pkg::DATA_W-1:0]  pwdata,
  output logic [oep_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // configuration registers
  logic [15:0] radius_start;
  logic [15:0] radius_delta;
  logic [15:0] zenith_start;
  logic [31:0] zenith_delta;
  logic [15:0] azimuth_start;
  logic [31:0] azimuth_delta;
  logic [47:0] center_point;

  oep_pkg::reg_index_t reg_index;

  assign pready    = 1'b1;
  assign busy      = rst;
  assign reg_index = oep_pkg::reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_start  <= 16'd4096;
      radius_delta  <= '0;
      zenith_start  <= '0;
      zenith_delta  <= '0;
      azimuth_start <= '0;
      azimuth_delta <= '0;
      center_point  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        oep_pkg::REG_RADIUS_START:  radius_start  <= pwdata[15:0];
        oep_pkg::REG_RADIUS_DELTA:  radius_delta  <= pwdata[15:0];
        oep_pkg::REG_ZENITH_START:  zenith_start  <= pwdata[15:0];
        oep_pkg::REG_ZENITH_DELTA:  zenith_delta  <= pwdata[31:0];
        oep_pkg::REG_AZIMUTH_START: azimuth_start <= pwdata[15:0];
        oep_pkg::REG_AZIMUTH_DELTA: azimuth_delta <= pwdata[31:0];
        oep_pkg::REG_CENTER_POINT:  center_point  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      oep_pkg::REG_RADIUS_START:  prdata = oep_pkg::DATA_W'(radius_start);
      oep_pkg::REG_RADIUS_DELTA:  prdata = oep_pkg::DATA_W'(radius_delta);
      oep_pkg::REG_ZENITH_START:  prdata = oep_pkg::DATA_W'(zenith_start);
      oep_pkg::REG_ZENITH_DELTA:  prdata = oep_pkg::DATA_W'(zenith_delta);
      oep_pkg::REG_AZIMUTH_START: prdata = oep_pkg::DATA_W'(azimuth_start);
      oep_pkg::REG_AZIMUTH_DELTA: prdata = oep_pkg::DATA_W'(azimuth_delta);
      oep_pkg::REG_CENTER_POINT:  prdata = oep_pkg::DATA_W'(center_point);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- stage A: angle and radius products ----------------
  logic signed [16:0]                 t_s;
  logic signed [48:0]                 pz_full;
  logic signed [48:0]                 pa_full;
  logic signed [oep_pkg::RSUM_W-1:0]  rsum;

  logic                               valid_a;
  logic [30:0]                        pz_a;
  logic [30:0]                        pa_a;
  logic signed [oep_pkg::RSUM_W-1:0]  rsum_a;

  always_comb begin
    t_s     = signed'({1'b0, progress});
    pz_full = 49'(signed'(zenith_delta)) * 49'(t_s);
    pa_full = 49'(signed'(azimuth_delta)) * 49'(t_s);
    rsum    = (oep_pkg::RSUM_W'(signed'(radius_start)) <<< 15)
            + oep_pkg::RSUM_W'(signed'(radius_delta)) * oep_pkg::RSUM_W'(t_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= start && !busy;
    end
    pz_a   <= pz_full[30:0];
    pa_a   <= pa_full[30:0];
    rsum_a <= rsum;
  end

  // ---------------- stage B: wrap angles, scale radius ----------------
  logic [30:0]                        pz_rnd;
  logic [30:0]                        pa_rnd;
  logic signed [oep_pkg::RPROD_W-1:0] rprod;
  logic signed [oep_pkg::RPROD_W-1:0] rprod_rnd;

  logic                               valid_b;
  logic [15:0]                        zen_b;
  logic [15:0]                        az_b;
  logic signed [oep_pkg::RQ_W-1:0]    rq_b;

  always_comb begin
    pz_rnd    = pz_a + 31'd16384;
    pa_rnd    = pa_a + 31'd16384;
    rprod     = oep_pkg::RPROD_W'(rsum_a) * oep_pkg::RPROD_W'(oep_pkg::EYE_S);
    rprod_rnd = (rprod + oep_pkg::HALF_RQ) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
    zen_b <= zenith_start + pz_rnd[30:15];
    az_b  <= azimuth_start + pa_rnd[30:15];
    rq_b  <= oep_pkg::RQ_W'(rprod_rnd);
  end

  // ---------------- CORDIC pipelines ----------------
  logic             zen_valid;
  logic             az_valid;
  oep_pkg::sincos_t zen_sc;
  oep_pkg::sincos_t az_sc;

  oep_cordic u_cordic_zen (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_b),
    .angle     (zen_b),
    .out_valid (zen_valid),
    .out       (zen_sc)
  );

  oep_cordic u_cordic_az (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_b),
    .angle     (az_b),
    .out_valid (az_valid),
    .out       (az_sc)
  );

  // carry the radius alongside the CORDIC stages
  logic signed [oep_pkg::RQ_W-1:0] rq_dly [oep_pkg::CORDIC_LAT];

  always_ff @(posedge clk) begin
    rq_dly[0] <= rq_b;
    for (int k = 1; k < oep_pkg::CORDIC_LAT; k++) begin
      rq_dly[k] <= rq_dly[k-1];
    end
  end

  // ---------------- stage C: direction products ----------------
  logic                                valid_c;
  logic signed [2*oep_pkg::TRIG_W-1:0] sc_p;
  logic signed [2*oep_pkg::TRIG_W-1:0] ss_p;
  logic signed [oep_pkg::TRIG_W-1:0]   cz_c;
  logic signed [oep_pkg::RQ_W-1:0]     rq_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else begin
      valid_c <= zen_valid && az_valid;
    end
    sc_p <= (2*oep_pkg::TRIG_W)'(zen_sc.sine) * (2*oep_pkg::TRIG_W)'(az_sc.cosine);
    ss_p <= (2*oep_pkg::TRIG_W)'(zen_sc.sine) * (2*oep_pkg::TRIG_W)'(az_sc.sine);
    cz_c <= zen_sc.cosine;
    rq_c <= rq_dly[oep_pkg::CORDIC_LAT-1];
  end

  // ---------------- stage D: round, scale by radius ----------------
  logic signed [2*oep_pkg::TRIG_W-1:0] sc_rnd;
  logic signed [2*oep_pkg::TRIG_W-1:0] ss_rnd;
  logic signed [oep_pkg::TRIG_W-1:0]   dir [3];

  logic                                valid_d;
  logic signed [oep_pkg::PROD_W-1:0]   prod [3];

  always_comb begin
    sc_rnd = (sc_p + oep_pkg::HALF_TRIG) >>> 15;
    ss_rnd = (ss_p + oep_pkg::HALF_TRIG) >>> 15;
    dir[0] = oep_pkg::TRIG_W'(sc_rnd);
    dir[1] = oep_pkg::TRIG_W'(ss_rnd);
    dir[2] = cz_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= valid_c;
    end
    for (int k = 0; k < 3; k++) begin
      prod[k] <= oep_pkg::PROD_W'(dir[k]) * oep_pkg::PROD_W'(rq_c);
    end
  end

  // ---------------- stage E: round, add center, clip ----------------
  logic signed [oep_pkg::PROD_W-1:0] prod_rnd [3];
  logic signed [oep_pkg::SUM_W-1:0]  sum      [3];
  logic signed [oep_pkg::SUM_W-1:0]  clip     [3];
  logic [2:0]                        lane_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_rnd[k] = (prod[k] + oep_pkg::HALF_PROD) >>> 27;
      sum[k]      = oep_pkg::SUM_W'(prod_rnd[k])
                  + oep_pkg::SUM_W'(signed'(center_point[16*k +: 16]));
      clip[k]     = sum[k];
      lane_sat[k] = 1'b0;
      if (sum[k] > oep_pkg::OUT_MAX) begin
        clip[k]     = oep_pkg::OUT_MAX;
        lane_sat[k] = 1'b1;
      end else if (sum[k] < oep_pkg::OUT_MIN) begin
        clip[k]     = oep_pkg::OUT_MIN;
        lane_sat[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_d;
    end
    eye_x     <= oep_pkg::OUT_W'(clip[0]);
    eye_y     <= oep_pkg::OUT_W'(clip[1]);
    eye_z     <= oep_pkg::OUT_W'(clip[2]);
    saturated <= |lane_sat;
  end

endmodule

[rtl/oep_cordic.sv]
// ----------------------------------------------------------------------------
// oep_cordic: pipelined CORDIC sine/cosine of a 16-bit turn angle
// One rotation per stage; results rounded to Q2.15 and clamped to +-1.
// ----------------------------------------------------------------------------
module oep_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [15:0]     angle,
  output logic            out_valid,
  output oep_pkg::sincos_t out
);

  function automatic logic signed [oep_pkg::TRIG_W-1:0] round_clamp(
    input logic signed [oep_pkg::XY_W:0] v
  );
    logic signed [oep_pkg::XY_W:0] s;
    s = (v + oep_pkg::HALF_CORDIC) >>> 15;
    if (s > oep_pkg::TRIG_MAX) begin
      s = oep_pkg::TRIG_MAX;
    end else if (s < oep_pkg::TRIG_MIN) begin
      s = oep_pkg::TRIG_MIN;
    end
    return oep_pkg::TRIG_W'(s);
  endfunction

  logic signed [oep_pkg::XY_W-1:0] x_s [oep_pkg::CORDIC_N+1];
  logic signed [oep_pkg::XY_W-1:0] y_s [oep_pkg::CORDIC_N+1];
  logic signed [oep_pkg::Z_W-1:0]  z_s [oep_pkg::CORDIC_N+1];
  logic                            neg_s [oep_pkg::CORDIC_N+1];
  logic                            v_s [oep_pkg::CORDIC_N+1];

  logic signed [16:0] s_ext;
  logic signed [16:0] s_red;
  logic               neg_red;
  logic signed [31:0] z_pre;

  // fold the angle into [-quarter, +quarter] turn, negate results later
  always_comb begin
    s_ext   = 17'(signed'(angle));
    s_red   = s_ext;
    neg_red = 1'b0;
    if (s_ext > 17'sd16384) begin
      s_red   = s_ext - 17'sd32768;
      neg_red = 1'b1;
    end else if (s_ext < -17'sd16384) begin
      s_red   = s_ext + 17'sd32768;
      neg_red = 1'b1;
    end
    z_pre = {s_red[15:0], 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= in_valid;
    end
    x_s[0]   <= oep_pkg::CORDIC_GAIN;
    y_s[0]   <= '0;
    z_s[0]   <= oep_pkg::Z_W'(z_pre);
    neg_s[0] <= neg_red;
  end

  for (genvar i = 0; i < oep_pkg::CORDIC_N; i++) begin : g_rot
    localparam logic signed [oep_pkg::Z_W-1:0] ATAN_I =
      signed'(oep_pkg::Z_W'(oep_pkg::ATAN_TURNS[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else begin
        v_s[i+1] <= v_s[i];
      end
      neg_s[i+1] <= neg_s[i];
      if (z_s[i] >= 0) begin
        x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] - ATAN_I;
      end else begin
        x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] + ATAN_I;
      end
    end
  end

  logic signed [oep_pkg::XY_W:0] x_fin;
  logic signed [oep_pkg::XY_W:0] y_fin;

  always_comb begin
    x_fin = (oep_pkg::XY_W+1)'(x_s[oep_pkg::CORDIC_N]);
    y_fin = (oep_pkg::XY_W+1)'(y_s[oep_pkg::CORDIC_N]);
    if (neg_s[oep_pkg::CORDIC_N]) begin
      x_fin = -x_fin;
      y_fin = -y_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_s[oep_pkg::CORDIC_N];
    end
    out.cosine <= round_clamp(x_fin);
    out.sine   <= round_clamp(y_fin);
  end

endmodule

[rtl/oep_checker.sv]
// ----------------------------------------------------------------------------
// oep_checker: port-level timing checks for orbit_eye_position
// Fixed latency, no spurious results, clip flag consistency, reset behavior.
// ----------------------------------------------------------------------------
module oep_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic signed [23:0]          eye_x,
  input logic signed [23:0]          eye_y,
  input logic signed [23:0]          eye_z,
  input logic                        saturated
);

  // every accepted transaction yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(oep_pkg::LATENCY) done)
    else $error("result missing after accepted transaction");

  // no result without an accepted transaction at the matching time
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, oep_pkg::LATENCY))
    else $error("result without matching transaction");

  // a clipped result has at least one coordinate at a range limit
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (eye_x == 24'h7FFFFF || eye_x == 24'h800000 ||
       eye_y == 24'h7FFFFF || eye_y == 24'h800000 ||
       eye_z == 24'h7FFFFF || eye_z == 24'h800000))
    else $error("saturated flag without clipped coordinate");

  // reset drops everything in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind orbit_eye_position oep_checker u_oep_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for orbit_eye_position
// Drives progress values through the command port, loads orbit registers over
// APB while the pipeline is empty, and checks every eye point against a
// fixed-point spherical-to-Cartesian predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module tb;

  localparam int     ORBIT_EYE_DIST = 512;
  localparam int     ROTATIONS      = 16;
  localparam int     ATAN_ENTRIES   = 24;
  localparam longint CORDIC_START_X = 652032874;
  localparam int     PIPE_DEPTH     = 23;
  localparam int     SETTLE_CYCLES  = PIPE_DEPTH + 8;
  localparam int     CYCLE_LIMIT    = 400000;
  localparam int     RANDOM_PHASES  = 32;
  localparam int     PHASE_ITEMS    = 55;
  localparam logic [2:0] UNMAPPED_INDEX = 3'd7;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_TURN [ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic [15:0]        t;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               sat;
  } eye_point_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [15:0] progress;
  logic done;
  logic signed [23:0] eye_x;
  logic signed [23:0] eye_y;
  logic signed [23:0] eye_z;
  logic saturated;
  logic psel;
  logic penable;
  logic pwrite;
  logic [oep_pkg::ADDR_W-1:0] paddr;
  logic [oep_pkg::DATA_W-1:0] pwdata;
  logic [oep_pkg::DATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the orbit registers
  logic signed [15:0] rad_start;
  logic signed [15:0] rad_delta;
  logic [15:0]        zen_start;
  logic [31:0]        zen_delta;
  logic [15:0]        azi_start;
  logic [31:0]        azi_delta;
  logic [47:0]        orbit_center;

  eye_point_t expected_eyes [$];
  int mismatch_count = 0;
  int cycle_count = 0;

  orbit_eye_position DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .progress  (progress),
    .done      (done),
    .eye_x     (eye_x),
    .eye_y     (eye_y),
    .eye_z     (eye_z),
    .saturated (saturated),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_eyes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] turn_angle(input logic [15:0] base,
                                             input logic [31:0] sweep,
                                             input logic [15:0] t);
    longint p;
    longint q;
    p = longint'($signed(sweep)) * longint'(t);
    q = (p + 16384) >>> 15;
    return base + q[15:0];
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 32768) return 32768;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [15:0] ang, output longint sine,
                                        output longint cosine);
    longint s;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    s = longint'($signed(ang));
    flip = 1'b0;
    // fold into the right half-plane, negate at the end
    if (s > 16384) begin
      s -= 32768;
      flip = 1'b1;
    end else if (s < -16384) begin
      s += 32768;
      flip = 1'b1;
    end
    x = CORDIC_START_X;
    y = 0;
    z = s * 65536;
    for (int i = 0; i < ROTATIONS && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TURN[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TURN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cosine = clamp_unit((x + 16384) >>> 15);
    sine   = clamp_unit((y + 16384) >>> 15);
  endfunction

  function automatic logic signed [23:0] place_coord(input longint prod_q27,
                                                      input logic signed [15:0] c,
                                                      inout bit clip);
    longint v;
    v = ((prod_q27 + (64'sd1 <<< 26)) >>> 27) + longint'(c);
    if (v > 8388607) begin
      v = 8388607;
      clip = 1'b1;
    end
    if (v < -8388608) begin
      v = -8388608;
      clip = 1'b1;
    end
    return v[23:0];
  endfunction

  function automatic eye_point_t predict_eye(input logic [15:0] t);
    eye_point_t e;
    longint rsum;
    longint rq;
    longint sz;
    longint cz;
    longint sa;
    longint ca;
    longint sc;
    longint ss;
    bit clip;
    rsum = longint'(rad_start) * 32768 + longint'(rad_delta) * longint'(t);
    rq = (rsum * ORBIT_EYE_DIST + 16384) >>> 15;
    cordic_sincos(turn_angle(zen_start, zen_delta, t), sz, cz);
    cordic_sincos(turn_angle(azi_start, azi_delta, t), sa, ca);
    sc = (sz * ca + 16384) >>> 15;
    ss = (sz * sa + 16384) >>> 15;
    clip = 1'b0;
    e.t   = t;
    e.x   = place_coord(sc * rq, orbit_center[15:0], clip);
    e.y   = place_coord(ss * rq, orbit_center[31:16], clip);
    e.z   = place_coord(cz * rq, orbit_center[47:32], clip);
    e.sat = clip;
    return e;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      oep_pkg::REG_RADIUS_START:  rad_start    = data[15:0];
      oep_pkg::REG_RADIUS_DELTA:  rad_delta    = data[15:0];
      oep_pkg::REG_ZENITH_START:  zen_start    = data[15:0];
      oep_pkg::REG_ZENITH_DELTA:  zen_delta    = data[31:0];
      oep_pkg::REG_AZIMUTH_START: azi_start    = data[15:0];
      oep_pkg::REG_AZIMUTH_DELTA: azi_delta    = data[31:0];
      oep_pkg::REG_CENTER_POINT:  orbit_center = data[47:0];
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_results
    eye_point_t want;
    if (!rst && done) begin
      if (expected_eyes.size() == 0) begin
        report_mismatch("result with no pending transaction");
      end else begin
        want = expected_eyes.pop_front();
        if (eye_x !== want.x)
          report_mismatch($sformatf("t=%0d eye_x %0d, expected %0d", want.t, eye_x, want.x));
        if (eye_y !== want.y)
          report_mismatch($sformatf("t=%0d eye_y %0d, expected %0d", want.t, eye_y, want.y));
        if (eye_z !== want.z)
          report_mismatch($sformatf("t=%0d eye_z %0d, expected %0d", want.t, eye_z, want.z));
        if (saturated !== want.sat)
          report_mismatch($sformatf("t=%0d saturated %b, expected %b", want.t, saturated,
                                    want.sat));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_progress(input logic [15:0] t);
    start    <= 1'b1;
    progress <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_eyes.push_back(predict_eye(t));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start    <= 1'b0;
      progress <= 16'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until the pipeline is empty
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_eyes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_orbit(input logic [15:0] rs, input logic [15:0] rd,
                            input logic [15:0] zs, input logic [31:0] zd,
                            input logic [15:0] as, input logic [31:0] ad,
                            input logic [47:0] center);
    wait_for_results();
    apb_write(oep_pkg::REG_RADIUS_START, {48'd0, rs});
    apb_write(oep_pkg::REG_RADIUS_DELTA, {48'd0, rd});
    apb_write(oep_pkg::REG_ZENITH_START, {48'd0, zs});
    apb_write(oep_pkg::REG_ZENITH_DELTA, {32'd0, zd});
    apb_write(oep_pkg::REG_AZIMUTH_START, {48'd0, as});
    apb_write(oep_pkg::REG_AZIMUTH_DELTA, {32'd0, ad});
    apb_write(oep_pkg::REG_CENTER_POINT, {16'd0, center});
  endtask

  function automatic logic [63:0] orbit_register_value(input logic [2:0] idx);
    logic [63:0] v;
    int pick;
    // upper bits carry junk that the block must drop
    v = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    case (idx)
      oep_pkg::REG_RADIUS_START, oep_pkg::REG_RADIUS_DELTA: begin
        if (pick == 0) v[15:0] = 16'h8000;
        else if (pick == 1) v[15:0] = 16'h7fff;
        else if (pick < 6) v[15:0] = 16'($urandom_range(0, 16384)) - 16'd4096;
      end
      oep_pkg::REG_ZENITH_DELTA, oep_pkg::REG_AZIMUTH_DELTA: begin
        if (pick == 0) v[31:0] = 32'h8000_0000;
        else if (pick == 1) v[31:0] = 32'h7fff_ffff;
        else if (pick < 6) v[31:0] = 32'($urandom_range(0, 262144)) - 32'd131072;
      end
      oep_pkg::REG_CENTER_POINT: begin
        if (pick == 0) v[47:0] = 48'h8000_8000_8000;
        else if (pick == 1) v[47:0] = 48'h7fff_7fff_7fff;
      end
      default: begin
        if (pick == 0) v[15:0] = 16'h0000;
        else if (pick == 1) v[15:0] = 16'hffff;
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_progress();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic run_orbit_items(input int count, input bit with_gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_progress(pick_progress());
        sent++;
      end
      if (with_gaps) idle_gap($urandom_range(0, 7));
    end
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_reset_defaults();
    send_progress(16'd0);
    send_progress(16'd32768);
    send_progress(16'd65535);
    idle_gap(3);
    send_progress(16'd1);
  endtask

  // one-turn-per-unit sweep makes the zenith angle equal to t, to hit the fold points
  task automatic test_quadrant_edges();
    load_orbit(16'd4096, 16'd2048, 16'd0, 32'd32768, 16'd12345, 32'd32768,
               {16'd100, 16'hff9c, 16'd7});
    send_progress(16'd16383);
    send_progress(16'd16384);
    send_progress(16'd16385);
    send_progress(16'd32768);
    idle_gap(2);
    send_progress(16'd49151);
    send_progress(16'd49152);
    send_progress(16'd49153);
    send_progress(16'd65535);
  endtask

  task automatic test_register_extremes();
    load_orbit(16'h7fff, 16'h7fff, 16'hffff, 32'h7fff_ffff, 16'hffff, 32'h7fff_ffff,
               48'h7fff_7fff_7fff);
    send_progress(16'd0);
    send_progress(16'd32768);
    send_progress(16'd65535);
    load_orbit(16'h8000, 16'h8000, 16'h0000, 32'h8000_0000, 16'h0000, 32'h8000_0000,
               48'h8000_8000_8000);
    send_progress(16'd0);
    send_progress(16'd32768);
    send_progress(16'd65535);
  endtask

  task automatic test_unknown_register();
    wait_for_results();
    apb_write(UNMAPPED_INDEX, {$urandom, $urandom});
    send_progress(16'd12000);
    send_progress(16'd40000);
  endtask

  task automatic test_random_orbits();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      for (int r = 0; r <= oep_pkg::REG_CENTER_POINT; r++)
        apb_write(3'(r), orbit_register_value(3'(r)));
      if (phase == 5) begin
        run_orbit_items(PHASE_ITEMS / 2, 1'b1);
        wait_for_results();
        run_orbit_items(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
      end else begin
        run_orbit_items(PHASE_ITEMS, (phase % 4) != 3);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    progress = 16'd0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rad_start    = 16'sd4096;
    rad_delta    = 16'sd0;
    zen_start    = 16'd0;
    zen_delta    = 32'd0;
    azi_start    = 16'd0;
    azi_delta    = 32'd0;
    orbit_center = 48'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_reset_defaults();
    test_quadrant_edges();
    test_register_extremes();
    test_unknown_register();
    test_random_orbits();
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
